// File: rtl/core/expadsr_pkg.sv
// expadsr_pkg: types, constants and reciprocal tables for the exponential adsr envelope
// used by every module of the envelope block, depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package expadsr_pkg;
   localparam int FRACTION_BITS = 16;
   localparam int KNOB_W = 12;
   localparam int TICK_W = 16;
   localparam int LEVEL_W = KNOB_W + FRACTION_BITS;
   localparam int CALC_W = LEVEL_W + 1;
   localparam int NUM_W = TICK_W + 28;
   localparam int DEN_W = 52;
   localparam int REM_W = DEN_W + 6;
   localparam int QUO_W = 29;
   localparam int EXP_W = 31;
   localparam int FRAC_W = 30;
   localparam int SCALE_W = 17;
   localparam int MUL_X_W = 36;
   localparam int MUL_Y_W = 32;
   localparam int PROD_W = MUL_X_W + MUL_Y_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int HORNER_TERMS = 12;

   localparam logic [TICK_W-1:0] TICK_RESET = 16'd350;
   localparam logic [EXP_W-1:0] EXP_ONE = 31'h4000_0000;
   localparam logic [PROD_W-1:0] PROD_HALF = PROD_W'(64'h2000_0000);
   localparam logic [EXP_W-1:0] EXP_INV_E = 31'd395007542;
   localparam logic [SCALE_W-1:0] ATTACK_SCALE = 17'd34092;
   localparam logic [SCALE_W-1:0] DECAY_SCALE = 17'd78549;
   localparam logic [SCALE_W-1:0] RELEASE_SCALE = 17'd75366;
   localparam logic [CALC_W-1:0] FULL_LEVEL = CALC_W'(5000) << FRACTION_BITS;
   localparam logic [CALC_W-1:0] PEAK_LEVEL = CALC_W'(4095) << FRACTION_BITS;
   localparam logic [CALC_W-1:0] ONE_LEVEL = CALC_W'(1) << FRACTION_BITS;
   localparam logic [CALC_W-1:0] SNAP_LEVEL = CALC_W'(3) << (FRACTION_BITS - 1);
   localparam logic [KNOB_W-1:0] RELEASE_HOLD = 12'd4080;
   localparam logic [KNOB_W-1:0] DAC_MAX = 12'd4095;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_NOTE_ON = 2'd1;
   localparam logic [1:0] OP_NOTE_OFF = 2'd2;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_NOTE_ON = 2'd1,
      CMD_NOTE_OFF = 2'd2,
      CMD_NOP = 2'd3
   } cmd_kind_type;

   typedef enum logic [2:0] {
      PH_OFF = 3'd0,
      PH_ATTACK = 3'd1,
      PH_DECAY = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [KNOB_W-1:0] attack;
      logic [KNOB_W-1:0] decay;
      logic [KNOB_W-1:0] sustain;
      logic [KNOB_W-1:0] release_k;
      logic [KNOB_W-1:0] gain;
   } cmd_type;

   typedef enum logic [4:0] {
      B_IDLE,
      B_SQ,
      B_CUBE,
      B_SCALE,
      B_CHECK,
      B_DIV,
      B_H_MUL,
      B_H_RCP,
      B_H_SUB,
      B_N_MUL,
      B_N_RND,
      B_LVL_MUL,
      B_LVL_SET,
      B_DAC_MUL,
      B_DAC_SET,
      B_LED_SQ,
      B_LED_CUBE,
      B_OUT
   } back_state_type;

   // floor(x / k) = (x * m) >> s for x below 2^31
   function automatic logic [31:0] rcp_mult(input logic [3:0] k);
      logic [31:0] m;
      unique case (k)
         4'd3: m = 32'd2863311531;
         4'd5: m = 32'd3435973837;
         4'd6: m = 32'd2863311531;
         4'd7: m = 32'd2454267027;
         4'd9: m = 32'd3817748708;
         4'd10: m = 32'd3435973837;
         4'd11: m = 32'd3123612579;
         4'd12: m = 32'd2863311531;
         default: m = 32'h8000_0000;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] rcp_shift(input logic [3:0] k);
      logic [5:0] s;
      unique case (k)
         4'd1: s = 6'd31;
         4'd2: s = 6'd32;
         4'd3, 4'd4: s = 6'd33;
         4'd5, 4'd6, 4'd7, 4'd8: s = 6'd34;
         default: s = 6'd35;
      endcase
      return s;
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/exponential_adsr_envelope.sv
// exponential_adsr_envelope: top level, front decode, command queue and envelope sequencer
// depends on expadsr_pkg, expadsr_front, expadsr_queue, expadsr_back
// note events, steady sustain and holds go from pop straight to the dac and led steps;
//   ticks that need e^-x also square (and for attack cube) the knob, scale, range-check,
//   divide bit-serially, run the Horner steps and multiply by 1/e n times, n the integer
//   part of x (up to 23); one item at a time, as multiplier and divider are shared
// reset: synchronous, phase off, level zero, tick time 350, queue and result register empty
`timescale 1ns / 1ps
`default_nettype none
module exponential_adsr_envelope
   import expadsr_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write_enable,
   input wire logic [TICK_W-1:0] csr_write_data,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_operation,
   input wire logic [KNOB_W-1:0] req_attack_knob,
   input wire logic [KNOB_W-1:0] req_decay_knob,
   input wire logic [KNOB_W-1:0] req_sustain_knob,
   input wire logic [KNOB_W-1:0] req_release_knob,
   input wire logic [KNOB_W-1:0] req_gain_knob,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [KNOB_W-1:0] rsp_dac_value,
   output logic [KNOB_W-1:0] rsp_led_brightness,
   output logic rsp_updated,
   output logic [2:0] rsp_phase_now
);
   logic push_valid, push_ready, pop_valid, pop_ready;
   cmd_type push_item, pop_item;

   expadsr_front u_front (
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_attack_knob(req_attack_knob),
      .req_decay_knob(req_decay_knob),
      .req_sustain_knob(req_sustain_knob),
      .req_release_knob(req_release_knob),
      .req_gain_knob(req_gain_knob),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item)
   );

   expadsr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item)
   );

   expadsr_back u_back (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_dac_value(rsp_dac_value),
      .rsp_led_brightness(rsp_led_brightness),
      .rsp_updated(rsp_updated),
      .rsp_phase_now(rsp_phase_now)
   );
endmodule
`default_nettype wire

// File: rtl/core/expadsr_front.sv
// expadsr_front: takes request items and classifies the operation into a command
// depends on expadsr_pkg
`timescale 1ns / 1ps
`default_nettype none
module expadsr_front
   import expadsr_pkg::*;
(
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_operation,
   input wire logic [KNOB_W-1:0] req_attack_knob,
   input wire logic [KNOB_W-1:0] req_decay_knob,
   input wire logic [KNOB_W-1:0] req_sustain_knob,
   input wire logic [KNOB_W-1:0] req_release_knob,
   input wire logic [KNOB_W-1:0] req_gain_knob,
   output logic push_valid,
   input wire logic push_ready,
   output cmd_type push_item
);
   cmd_kind_type kind;

   always_comb begin
      unique case (req_operation)
         OP_TICK: kind = CMD_TICK;
         OP_NOTE_ON: kind = CMD_NOTE_ON;
         OP_NOTE_OFF: kind = CMD_NOTE_OFF;
         default: kind = CMD_NOP;
      endcase
   end

   assign req_ready = push_ready;
   assign push_valid = req_valid;
   assign push_item = '{kind: kind, attack: req_attack_knob, decay: req_decay_knob,
                        sustain: req_sustain_knob, release_k: req_release_knob,
                        gain: req_gain_knob};
endmodule
`default_nettype wire

// File: rtl/core/expadsr_queue.sv
// expadsr_queue: short command queue between front and back
// depends on expadsr_pkg
`timescale 1ns / 1ps
`default_nettype none
module expadsr_queue
   import expadsr_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic push_valid,
   output logic push_ready,
   input wire cmd_type push_item,
   output logic pop_valid,
   input wire logic pop_ready,
   output cmd_type pop_item
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/expadsr_back.sv
// expadsr_back: envelope sequencer with one shared multiplier, divider and exp steps
// holds phase, level, tick time and the result register; depends on expadsr_pkg
`timescale 1ns / 1ps
`default_nettype none
module expadsr_back
   import expadsr_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write_enable,
   input wire logic [TICK_W-1:0] csr_write_data,
   input wire logic pop_valid,
   output logic pop_ready,
   input wire cmd_type pop_item,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [KNOB_W-1:0] rsp_dac_value,
   output logic [KNOB_W-1:0] rsp_led_brightness,
   output logic rsp_updated,
   output logic [2:0] rsp_phase_now
);
   back_state_type state_ff, state_in;
   cmd_type cmd_ff;
   logic [TICK_W-1:0] tick_ff;
   phase_type phase_ff, phase_new_ff;
   logic [LEVEL_W-1:0] level_ff, level_new_ff;
   logic [CALC_W-1:0] base_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [REM_W-1:0] rem_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [4:0] step_ff;
   logic [EXP_W-1:0] p_ff;
   logic [FRAC_W-1:0] f_ff;
   logic [3:0] k_ff;
   logic [4:0] n_ff;
   logic [KNOB_W-1:0] knob_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic cube_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [KNOB_W-1:0] dac_ff;
   logic rsp_valid_ff;
   logic [KNOB_W-1:0] rsp_dac_ff, rsp_led_ff;
   logic rsp_upd_ff;
   phase_type rsp_phase_ff;

   // decision for a new command
   logic dec_exp, dec_cube;
   logic [KNOB_W-1:0] dec_knob;
   logic [SCALE_W-1:0] dec_scale;
   logic [NUM_W-1:0] dec_num;
   logic [CALC_W-1:0] dec_base;
   logic [LEVEL_W-1:0] dec_level, dec_sus;
   phase_type dec_phase;

   logic [MUL_X_W-1:0] mul_x;
   logic [MUL_Y_W-1:0] mul_y;
   logic [PROD_W-1:0] prod_in;
   logic out_free, take_cmd, load_rsp;

   logic [DEN_W+4:0] den_limit;
   logic [REM_W-1:0] den_shift, rem_diff;
   logic rem_ge;
   logic [QUO_W-1:0] quo_next;
   logic [PROD_W-1:0] horner_q, rounded;
   logic [CALC_W-1:0] rnd, sus_calc, lvl_attack, lvl_decay;
   logic [PROD_W-1:0] dac_raw;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign dec_sus = {pop_item.sustain, FRACTION_BITS'(0)};

   always_comb begin
      dec_exp = 1'b0;
      dec_cube = 1'b0;
      dec_knob = pop_item.attack;
      dec_scale = ATTACK_SCALE;
      dec_num = {tick_ff, 28'd0};
      dec_base = '0;
      dec_level = level_ff;
      dec_phase = phase_ff;
      unique case (pop_item.kind)
         CMD_NOTE_ON: dec_phase = PH_ATTACK;
         CMD_NOTE_OFF: dec_phase = PH_RELEASE;
         CMD_TICK: begin
            unique case (phase_ff)
               PH_ATTACK: begin
                  if (pop_item.attack == '0) begin
                     dec_level = PEAK_LEVEL[LEVEL_W-1:0];
                     dec_phase = PH_DECAY;
                  end else begin
                     dec_exp = 1'b1;
                     dec_cube = 1'b1;
                     dec_base = FULL_LEVEL - CALC_W'(level_ff);
                  end
               end
               PH_DECAY: begin
                  if (pop_item.decay != '0 && level_ff > dec_sus) begin
                     dec_exp = 1'b1;
                     dec_knob = pop_item.decay;
                     dec_scale = DECAY_SCALE;
                     dec_num = NUM_W'({tick_ff, 16'd0});
                     dec_base = CALC_W'(level_ff - dec_sus);
                  end else begin
                     dec_level = dec_sus;
                     dec_phase = PH_SUSTAIN;
                  end
               end
               PH_SUSTAIN: dec_level = dec_sus;
               PH_RELEASE: begin
                  if (level_ff != '0) begin
                     if (pop_item.release_k < RELEASE_HOLD) begin
                        if (pop_item.release_k != '0 && CALC_W'(level_ff) > ONE_LEVEL) begin
                           dec_exp = 1'b1;
                           dec_knob = pop_item.release_k;
                           dec_scale = RELEASE_SCALE;
                           dec_num = NUM_W'({tick_ff, 16'd0});
                           dec_base = CALC_W'(level_ff);
                        end else begin
                           dec_level = '0;
                        end
                     end
                  end else begin
                     dec_phase = PH_OFF;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (pop_valid) begin
            state_in = dec_exp ? B_SQ : B_DAC_MUL;
         end
         B_SQ: state_in = cube_ff ? B_CUBE : B_SCALE;
         B_CUBE: state_in = B_SCALE;
         B_SCALE: state_in = B_CHECK;
         B_CHECK: state_in = (NUM_W'(num_ff) >= den_limit) ? B_LVL_MUL : B_DIV;
         B_DIV: if (step_ff == 5'(QUO_W - 1)) begin
            state_in = B_H_MUL;
         end
         B_H_MUL: state_in = B_H_RCP;
         B_H_RCP: state_in = B_H_SUB;
         B_H_SUB: begin
            if (k_ff != 4'd1) begin
               state_in = B_H_MUL;
            end else begin
               state_in = (n_ff == '0) ? B_LVL_MUL : B_N_MUL;
            end
         end
         B_N_MUL: state_in = B_N_RND;
         B_N_RND: state_in = (n_ff == 5'd1) ? B_LVL_MUL : B_N_MUL;
         B_LVL_MUL: state_in = B_LVL_SET;
         B_LVL_SET: state_in = B_DAC_MUL;
         B_DAC_MUL: state_in = B_DAC_SET;
         B_DAC_SET: state_in = B_LED_SQ;
         B_LED_SQ: state_in = B_LED_CUBE;
         B_LED_CUBE: state_in = B_OUT;
         B_OUT: if (out_free) begin
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // outputs: multiplier operands and handshakes
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      take_cmd = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         B_IDLE: take_cmd = pop_valid;
         B_SQ: begin
            mul_x = MUL_X_W'(knob_ff);
            mul_y = MUL_Y_W'(knob_ff);
         end
         B_CUBE: begin
            mul_x = MUL_X_W'(prod_ff[23:0]);
            mul_y = MUL_Y_W'(knob_ff);
         end
         B_SCALE: begin
            mul_x = prod_ff[MUL_X_W-1:0];
            mul_y = MUL_Y_W'(scale_ff);
         end
         B_H_MUL: begin
            mul_x = MUL_X_W'(p_ff);
            mul_y = MUL_Y_W'(f_ff);
         end
         B_H_RCP: begin
            mul_x = MUL_X_W'(prod_ff[60:30]);
            mul_y = rcp_mult(k_ff);
         end
         B_N_MUL: begin
            mul_x = MUL_X_W'(p_ff);
            mul_y = MUL_Y_W'(EXP_INV_E);
         end
         B_LVL_MUL: begin
            mul_x = MUL_X_W'(base_ff);
            mul_y = MUL_Y_W'(p_ff);
         end
         B_DAC_MUL: begin
            mul_x = MUL_X_W'(level_new_ff);
            mul_y = MUL_Y_W'(cmd_ff.gain);
         end
         B_LED_SQ: begin
            mul_x = MUL_X_W'(dac_ff);
            mul_y = MUL_Y_W'(dac_ff);
         end
         B_LED_CUBE: begin
            mul_x = MUL_X_W'(prod_ff[23:0]);
            mul_y = MUL_Y_W'(dac_ff);
         end
         B_OUT: load_rsp = out_free;
         default: ;
      endcase
   end

   assign pop_ready = take_cmd;
   assign prod_in = PROD_W'(mul_x) * PROD_W'(mul_y);

   assign den_limit = {prod_ff[DEN_W-1:0], 4'd0} + {1'b0, prod_ff[DEN_W-1:0], 3'd0};
   assign den_shift = REM_W'({den_ff, 4'd0});
   assign rem_ge = rem_ff >= den_shift;
   assign rem_diff = rem_ge ? rem_ff - den_shift : rem_ff;
   assign quo_next = {quo_ff[QUO_W-2:0], rem_ge};
   assign horner_q = prod_ff >> rcp_shift(k_ff);
   assign rounded = prod_ff + PROD_HALF;
   assign rnd = rounded[CALC_W+29:30];
   assign sus_calc = CALC_W'({cmd_ff.sustain, FRACTION_BITS'(0)});
   assign lvl_attack = FULL_LEVEL - rnd;
   assign lvl_decay = sus_calc + rnd;
   assign dac_raw = prod_ff >> (FRACTION_BITS + KNOB_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         tick_ff <= TICK_RESET;
         phase_ff <= PH_OFF;
         level_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            tick_ff <= csr_write_data;
         end
         if (load_rsp) begin
            phase_ff <= phase_new_ff;
            level_ff <= level_new_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      // led cube stays in the product register while the result waits
      if (state_ff != B_OUT) begin
         prod_ff <= prod_in;
      end
      unique case (state_ff)
         B_IDLE: begin
            cmd_ff <= pop_item;
            knob_ff <= dec_knob;
            scale_ff <= dec_scale;
            cube_ff <= dec_cube;
            num_ff <= dec_num;
            base_ff <= dec_base;
            level_new_ff <= dec_level;
            phase_new_ff <= dec_phase;
         end
         B_CHECK: begin
            den_ff <= prod_ff[DEN_W-1:0];
            rem_ff <= REM_W'(num_ff);
            quo_ff <= '0;
            step_ff <= '0;
            p_ff <= '0;
         end
         B_DIV: begin
            rem_ff <= {rem_diff[REM_W-2:0], 1'b0};
            quo_ff <= quo_next;
            step_ff <= step_ff + 1'b1;
            f_ff <= {quo_next[23:0], 6'd0};
            n_ff <= quo_next[28:24];
            p_ff <= EXP_ONE;
            k_ff <= 4'(HORNER_TERMS);
         end
         B_H_SUB: begin
            p_ff <= EXP_ONE - horner_q[EXP_W-1:0];
            k_ff <= k_ff - 1'b1;
         end
         B_N_RND: begin
            p_ff <= rounded[EXP_W+29:30];
            n_ff <= n_ff - 1'b1;
         end
         B_LVL_SET: begin
            unique case (phase_ff)
               PH_ATTACK: begin
                  if (lvl_attack >= PEAK_LEVEL) begin
                     level_new_ff <= PEAK_LEVEL[LEVEL_W-1:0];
                     phase_new_ff <= PH_DECAY;
                  end else begin
                     level_new_ff <= lvl_attack[LEVEL_W-1:0];
                  end
               end
               PH_DECAY: begin
                  if (lvl_decay <= sus_calc + SNAP_LEVEL) begin
                     level_new_ff <= sus_calc[LEVEL_W-1:0];
                     phase_new_ff <= PH_SUSTAIN;
                  end else begin
                     level_new_ff <= lvl_decay[LEVEL_W-1:0];
                  end
               end
               PH_RELEASE: level_new_ff <= rnd[LEVEL_W-1:0];
               default: ;
            endcase
         end
         B_DAC_SET: begin
            dac_ff <= (dac_raw > PROD_W'(DAC_MAX)) ? DAC_MAX : dac_raw[KNOB_W-1:0];
         end
         B_OUT: begin
            if (load_rsp) begin
               rsp_dac_ff <= dac_ff;
               rsp_led_ff <= prod_ff[35:24];
               rsp_upd_ff <= (level_new_ff != level_ff);
               rsp_phase_ff <= phase_new_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dac_value = rsp_dac_ff;
   assign rsp_led_brightness = rsp_led_ff;
   assign rsp_updated = rsp_upd_ff;
   assign rsp_phase_now = rsp_phase_ff;
endmodule
`default_nettype wire

// File: sim/tb.sv
// tb: self-checking testbench for exponential_adsr_envelope, with a scoreboard class and a bit-exact envelope predictor
// depends on expadsr_pkg and the exponential_adsr_envelope rtl
`timescale 1ns / 1ps
module tb;
   import expadsr_pkg::*;

   typedef struct {
      logic [KNOB_W-1:0] dac;
      logic [KNOB_W-1:0] led;
      logic updated;
      logic [2:0] ph;
   } env_result_type;

   class envelope_scoreboard;
      localparam bit [63:0] Q30_ONE = 64'd1 << 30;
      localparam bit [63:0] Q30_HALF = 64'd1 << 29;
      localparam bit [63:0] Q30_INV_E = 64'd395007542;
      bit [63:0] tick_time;
      logic [2:0] ph;
      bit [63:0] level;
      env_result_type expected_q[$];
      int errors;
      int matched;

      function new();
         tick_time = 64'd350;
         ph = PH_OFF;
         level = 0;
         errors = 0;
         matched = 0;
      endfunction

      function bit [63:0] scale_q30(bit [63:0] a, bit [63:0] e);
         return (a >> 30) * e + (((a & (Q30_ONE - 1)) * e + Q30_HALF) >> 30);
      endfunction

      // e^-(num/den) in q.30
      function bit [63:0] decay_factor(bit [63:0] num, bit [63:0] den);
         bit [63:0] q, r, f, p, n;
         if (den == 0 || num >= 64'd24 * den) return 0;
         q = num / den;
         r = num % den;
         for (int i = 0; i < 24; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               r = r - den;
               q = q | 1;
            end
         end
         n = q >> 24;
         f = (q & 64'hFF_FFFF) << 6;
         p = Q30_ONE;
         for (int k = 12; k >= 1; k--) p = Q30_ONE - ((f * p) >> 30) / k;
         for (bit [63:0] i = 0; i < n; i++) p = (p * Q30_INV_E + Q30_HALF) >> 30;
         return p;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_input(cmd_kind_type op, bit [63:0] a, bit [63:0] d, bit [63:0] s,
                               bit [63:0] r, bit [63:0] g);
         bit [63:0] full, peak, sus, lvl, diff, dac;
         env_result_type res;
         full = 64'd5000 << FRACTION_BITS;
         peak = 64'd4095 << FRACTION_BITS;
         sus = s << FRACTION_BITS;
         lvl = level;
         if (op == CMD_NOTE_ON) ph = PH_ATTACK;
         else if (op == CMD_NOTE_OFF) ph = PH_RELEASE;
         else if (op == CMD_TICK) begin
            case (ph)
               PH_ATTACK: begin
                  if (a == 0) lvl = full;
                  else begin
                     diff = lvl < full ? full - lvl : 0;
                     lvl = full - scale_q30(diff,
                        decay_factor(tick_time << 28, a * a * a * 64'd34092));
                  end
                  if (lvl >= peak) begin
                     lvl = peak;
                     ph = PH_DECAY;
                  end
               end
               PH_DECAY: begin
                  if (d != 0 && lvl > sus)
                     lvl = sus + scale_q30(lvl - sus,
                        decay_factor(tick_time << 16, d * d * 64'd78549));
                  else lvl = 0;
                  if (lvl <= sus + (64'd3 << (FRACTION_BITS - 1))) begin
                     lvl = sus;
                     ph = PH_SUSTAIN;
                  end
               end
               PH_SUSTAIN: lvl = sus;
               PH_RELEASE: begin
                  if (lvl > 0) begin
                     if (r < 4080) begin
                        if (r != 0 && lvl > (64'd1 << FRACTION_BITS))
                           lvl = scale_q30(lvl,
                              decay_factor(tick_time << 16, r * r * 64'd75366));
                        else lvl = 0;
                     end
                  end else ph = PH_OFF;
               end
               default: ;
            endcase
         end
         dac = (lvl * g) >> (FRACTION_BITS + 12);
         if (dac > 4095) dac = 4095;
         res.dac = dac[11:0];
         res.led = ((dac * dac * dac) >> 24) & 64'hFFF;
         res.updated = (lvl != level);
         res.ph = ph;
         level = lvl;
         expected_q.push_back(res);
      endfunction

      function void check_result(logic [KNOB_W-1:0] dac, logic [KNOB_W-1:0] led,
                                 logic updated, logic [2:0] phn);
         env_result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t unexpected result dac %0d phase %0d", $time, dac, phn);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (dac !== e.dac) begin
            $display("%0t dac_value expected %0d actual %0d", $time, e.dac, dac);
            errors++;
         end
         if (led !== e.led) begin
            $display("%0t led_brightness expected %0d actual %0d", $time, e.led, led);
            errors++;
         end
         if (updated !== e.updated) begin
            $display("%0t updated expected %0d actual %0d", $time, e.updated, updated);
            errors++;
         end
         if (phn !== e.ph) begin
            $display("%0t phase_now expected %0d actual %0d", $time, e.ph, phn);
            errors++;
         end
         matched++;
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [TICK_W-1:0] csr_write_data;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_operation;
   logic [KNOB_W-1:0] req_attack_knob, req_decay_knob, req_sustain_knob;
   logic [KNOB_W-1:0] req_release_knob, req_gain_knob;
   logic rsp_valid;
   logic rsp_ready;
   logic [KNOB_W-1:0] rsp_dac_value, rsp_led_brightness;
   logic rsp_updated;
   logic [2:0] rsp_phase_now;

   envelope_scoreboard sb;
   int items_sent;
   int hold_left;
   bit held_once;
   bit calm;

   exponential_adsr_envelope i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_attack_knob(req_attack_knob),
      .req_decay_knob(req_decay_knob),
      .req_sustain_knob(req_sustain_knob),
      .req_release_knob(req_release_knob),
      .req_gain_knob(req_gain_knob),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_dac_value(rsp_dac_value),
      .rsp_led_brightness(rsp_led_brightness),
      .rsp_updated(rsp_updated),
      .rsp_phase_now(rsp_phase_now)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // handshakes seen at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_input(cmd_kind_type'(req_operation), req_attack_knob, req_decay_knob,
                          req_sustain_knob, req_release_knob, req_gain_knob);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_dac_value, rsp_led_brightness, rsp_updated, rsp_phase_now);
      end
   end

   // receiver with random stalls and one long hold-off
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      held_once = 0;
      forever begin
         @(negedge clock);
         if (!held_once && sb != null && sb.matched == 300) begin
            held_once = 1;
            hold_left = 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (calm) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 99) >= 28);
      end
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   // caller is at a falling edge, returns at a falling edge
   task automatic send_item(cmd_kind_type op, int a, int d, int s, int r, int g);
      if (!calm && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_attack_knob <= a;
      req_decay_knob <= d;
      req_sustain_knob <= s;
      req_release_knob <= r;
      req_gain_knob <= g;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_tick_time(int v);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.tick_time = v;
   endtask

   function automatic int time_knob();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 250);
   endfunction

   task automatic run_phase(int n);
      int a, d, s, r, g, last;
      last = items_sent + n;
      while (items_sent < last) begin
         if ($urandom_range(0, 99) < 12) begin
            send_item(cmd_kind_type'($urandom_range(0, 3)), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
         end else begin
            a = time_knob();
            d = time_knob();
            s = $urandom_range(0, 4095);
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(4080, 4095) : time_knob();
            g = $urandom_range(0, 4095);
            send_item(CMD_NOTE_ON, a, d, s, r, g);
            repeat ($urandom_range(1, 50)) begin
               if (items_sent >= last) break;
               if ($urandom_range(0, 9) == 0) a = time_knob();
               if ($urandom_range(0, 9) == 0) g = $urandom_range(0, 4095);
               send_item(CMD_TICK, a, d, s, r, g);
            end
            if ($urandom_range(0, 7) == 0) send_item(CMD_NOTE_ON, a, d, s, r, g);
            send_item(CMD_NOTE_OFF, a, d, s, r, g);
            repeat ($urandom_range(1, 40)) begin
               if (items_sent >= last) break;
               if ($urandom_range(0, 9) == 0) r = time_knob();
               send_item(CMD_TICK, a, d, s, r, g);
            end
         end
      end
   endtask

   initial begin
      sb = new();
      items_sent = 0;
      calm = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_operation = CMD_TICK;
      req_attack_knob = '0;
      req_decay_knob = '0;
      req_sustain_knob = '0;
      req_release_knob = '0;
      req_gain_knob = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners at the reset tick time
      send_item(CMD_TICK, 0, 0, 0, 0, 0);
      send_item(CMD_NOP, 4095, 4095, 4095, 4095, 4095);
      send_item(CMD_NOTE_OFF, 0, 0, 0, 0, 4095);
      send_item(CMD_TICK, 0, 0, 0, 0, 4095);
      send_item(CMD_NOTE_ON, 0, 0, 2000, 0, 4095);
      send_item(CMD_TICK, 0, 0, 2000, 0, 4095);
      send_item(CMD_TICK, 0, 0, 2000, 0, 4095);
      send_item(CMD_TICK, 0, 0, 2000, 0, 4095);
      send_item(CMD_NOTE_OFF, 0, 0, 2000, 4095, 4095);
      send_item(CMD_TICK, 0, 0, 2000, 4095, 4095);
      send_item(CMD_TICK, 0, 0, 2000, 4080, 2048);
      send_item(CMD_TICK, 0, 0, 2000, 30, 4095);
      send_item(CMD_TICK, 0, 0, 2000, 0, 4095);
      send_item(CMD_TICK, 0, 0, 2000, 0, 4095);
      send_item(CMD_NOTE_ON, 4095, 4095, 4095, 4095, 4095);
      send_item(CMD_TICK, 4095, 4095, 4095, 4095, 4095);
      send_item(CMD_NOTE_ON, 1, 0, 4095, 0, 4095);
      send_item(CMD_TICK, 1, 0, 4095, 0, 4095);
      send_item(CMD_TICK, 1, 4095, 4095, 0, 4095);
      send_item(CMD_TICK, 1, 20, 4095, 0, 0);
      send_item(CMD_NOTE_ON, 0, 30, 100, 0, 4095);
      send_item(CMD_TICK, 0, 30, 100, 0, 4095);
      send_item(CMD_TICK, 0, 30, 100, 0, 4095);

      run_phase(300);
      write_tick_time(65535);
      calm = 1;
      run_phase(300);
      calm = 0;
      write_tick_time(1);
      run_phase(250);
      write_tick_time(0);
      run_phase(150);
      write_tick_time($urandom_range(1, 65535));
      run_phase(300);
      write_tick_time(350);
      run_phase(330);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("run covered %0d items over six tick time settings, %0d results checked",
               items_sent, sb.matched);
      $display("long receiver hold-off done: %0d, mismatches: %0d", held_once, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// File: sim.f
rtl/core/expadsr_pkg.sv
rtl/core/expadsr_front.sv
rtl/core/expadsr_queue.sv
rtl/core/expadsr_back.sv
rtl/core/exponential_adsr_envelope.sv
sim/tb.sv
